FILE: design/kfd_pkg.sv
// ---------------------------------------------------------------------------
// kfd_pkg: shared types for the KWP2000 frame deframer
// Phase and result kind codes, format field codes, beat structs.
// ---------------------------------------------------------------------------
package kfd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TARGET  = 3'd1,
    PH_SOURCE  = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_DATA    = 3'd4,
    PH_CHECK   = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA       = 3'd0,
    K_OK         = 3'd1,
    K_CKSUM      = 3'd2,
    K_FORMAT     = 3'd3,
    K_ZEROLEN    = 3'd4,
    K_INCOMPLETE = 3'd5
  } kind_t;

  // format byte top bits
  localparam logic [1:0] FMT_NONE = 2'b00;
  localparam logic [1:0] FMT_CARB = 2'b01;
  localparam logic [1:0] FMT_PHYS = 2'b10;
  localparam logic [1:0] FMT_FUNC = 2'b11;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] target_addr;
    logic [7:0] source_addr;
    logic       functional;
    logic [7:0] payload_len;
  } result_t;

endpackage

FILE: design/kfd_in_reg.sv
// ---------------------------------------------------------------------------
// kfd_in_reg: input register
// Holds one accepted beat until the parser consumes it.
// ---------------------------------------------------------------------------
module kfd_in_reg
  import kfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     item_valid,
  output in_item_t item,
  input  logic     take
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

FILE: design/kfd_parser.sv
// ---------------------------------------------------------------------------
// kfd_parser: frame parser
// Frame state and single-step update per beat; emits at most one result.
// ---------------------------------------------------------------------------
module kfd_parser
  import kfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  in_item_t item,
  input  logic     res_ready,
  output logic     take,
  output logic     res_valid,
  output result_t  res
);

  phase_t     phase, phase_next;
  logic [7:0] format_byte, format_byte_next;
  logic [7:0] target_held, target_held_next;
  logic [7:0] source_held, source_held_next;
  logic [7:0] length_held, length_held_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic       first_pending, first_pending_next;
  logic       emit;
  kind_t      kind;
  logic [7:0] b;
  logic [1:0] top;
  logic [5:0] dl;

  assign take = item_valid && res_ready;
  assign b    = item.rx_byte;

  always_comb begin
    phase_next         = phase;
    format_byte_next   = format_byte;
    target_held_next   = target_held;
    source_held_next   = source_held;
    length_held_next   = length_held;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    first_pending_next = first_pending;
    emit               = 1'b0;
    kind               = K_DATA;
    top                = b[7:6];
    dl                 = format_byte[5:0];

    if (item.func) begin
      if (phase inside {PH_TARGET, PH_SOURCE, PH_LENGTH, PH_DATA, PH_CHECK}) begin
        emit = 1'b1;
        kind = K_INCOMPLETE;
      end
      phase_next = PH_IDLE;
    end else begin
      if (phase != PH_IDLE && phase != PH_DISCARD) begin
        running_sum_next = running_sum + b;
      end
      case (phase)
        PH_IDLE: begin
          if (b != 8'd0) begin
            format_byte_next = b;
            target_held_next = 8'd0;
            source_held_next = 8'd0;
            length_held_next = 8'd0;
            bytes_left_next  = 8'd0;
            running_sum_next = b;
            if (top == FMT_CARB || (top == FMT_NONE && first_pending)) begin
              phase_next = PH_DISCARD;
              emit       = 1'b1;
              kind       = K_FORMAT;
            end else if (top == FMT_PHYS || top == FMT_FUNC) begin
              phase_next = PH_TARGET;
            end else if (b[5:0] == 6'd0) begin
              phase_next = PH_LENGTH;
            end else begin
              length_held_next = {2'b00, b[5:0]};
              bytes_left_next  = {2'b00, b[5:0]};
              phase_next       = PH_DATA;
            end
          end
        end
        PH_TARGET: begin
          target_held_next = b;
          phase_next       = PH_SOURCE;
        end
        PH_SOURCE: begin
          source_held_next = b;
          if (dl == 6'd0) begin
            phase_next = PH_LENGTH;
          end else begin
            length_held_next = {2'b00, dl};
            bytes_left_next  = {2'b00, dl};
            phase_next       = PH_DATA;
          end
        end
        PH_LENGTH: begin
          length_held_next = b;
          if (b == 8'd0) begin
            phase_next = PH_DISCARD;
            emit       = 1'b1;
            kind       = K_ZEROLEN;
          end else begin
            bytes_left_next = b;
            phase_next      = PH_DATA;
          end
        end
        PH_DATA: begin
          bytes_left_next = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_CHECK;
          end
          emit = 1'b1;
          kind = K_DATA;
        end
        PH_CHECK: begin
          // sum excludes the checksum byte itself
          running_sum_next = running_sum;
          emit             = 1'b1;
          if (running_sum == b) begin
            first_pending_next = 1'b0;
            phase_next         = PH_IDLE;
            kind               = K_OK;
          end else begin
            phase_next = PH_DISCARD;
            kind       = K_CKSUM;
          end
        end
        default: begin
          phase_next = PH_DISCARD;
        end
      endcase
    end
  end

  always_comb begin
    res.kind         = kind;
    res.payload_byte = (kind == K_DATA) ? b : 8'd0;
    res.target_addr  = target_held_next;
    res.source_addr  = source_held_next;
    res.functional   = (format_byte_next[7:6] == FMT_FUNC);
    res.payload_len  = length_held_next;
  end

  assign res_valid = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      format_byte   <= 8'd0;
      target_held   <= 8'd0;
      source_held   <= 8'd0;
      length_held   <= 8'd0;
      bytes_left    <= 8'd0;
      running_sum   <= 8'd0;
      first_pending <= 1'b1;
    end else if (take) begin
      phase         <= phase_next;
      format_byte   <= format_byte_next;
      target_held   <= target_held_next;
      source_held   <= source_held_next;
      length_held   <= length_held_next;
      bytes_left    <= bytes_left_next;
      running_sum   <= running_sum_next;
      first_pending <= first_pending_next;
    end
  end

endmodule

FILE: design/kfd_out_buf.sv
// ---------------------------------------------------------------------------
// kfd_out_buf: result register with skid
// Two-entry output buffer; head entry drives the master side.
// ---------------------------------------------------------------------------
module kfd_out_buf
  import kfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_valid,
  input  result_t wr_data,
  output logic    wr_ready,
  output logic    rd_valid,
  input  logic    rd_ready,
  output result_t rd_data
);

  logic [1:0] count;
  result_t    e0, e1;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = e0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        e0 <= wr_data;
      end else begin
        e1 <= wr_data;
      end
    end else if (pop && !push) begin
      e0 <= e1;
    end else if (pop && push) begin
      e0 <= wr_data;
    end
  end

endmodule

FILE: design/kwp2000_frame_deframer_unit.sv
// ---------------------------------------------------------------------------
// kwp2000_frame_deframer_unit: ISO 14230 frame deframer
// Parses received bus bytes and gap events into payload and frame status.
// ---------------------------------------------------------------------------
// Each input beat is a received byte or a bus idle gap (tuser = 1). The block
// sustains one beat per clock while the output buffer has room: the beat sits
// in an input register, the frame parser computes its state update and any
// result combinationally from it, and any result lands in a two-entry output
// buffer, whose head entry drives m_tvalid. Input stalls only when both output
// buffer entries are held by m_tready low.
// Payload bytes come out as they arrive (kind 0), followed by one frame-end
// status beat carrying length and addresses. After an error, bytes are
// dropped until a gap.
module kwp2000_frame_deframer_unit
  import kfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] payload_byte, [15:8] target_addr,
                                 // [23:16] source_addr, [24] functional,
                                 // [32:25] payload_len, [39:33] zero
  output logic [2:0]  m_tuser    // [2:0] kind
);

  in_item_t in_item, item;
  logic     item_valid, take, res_valid, buf_ready;
  result_t  res, head;

  assign in_item.func    = s_tuser;
  assign in_item.rx_byte = s_tdata;

  kfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  kfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (buf_ready),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  kfd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_data  (res),
    .wr_ready (buf_ready),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (head)
  );

  assign m_tuser = head.kind;
  assign m_tdata = {7'd0, head.payload_len, head.functional, head.source_addr,
                    head.target_addr, head.payload_byte};

endmodule
